@@ rtl/btp_pkg.sv @@
// Package for the branch target predictor: counter and address constants,
// command and branch-kind codes, and the zero-compare condition function.
// No dependencies.
package btp_pkg;

    // Table geometry and address width
    localparam int unsigned BTP_ENTRIES_DEF = 16;
    localparam int unsigned PC_W            = 32;
    localparam int unsigned CTR_W           = 3;
    localparam int unsigned KIND_W          = 3;

    // Saturating counter levels
    localparam logic [CTR_W-1:0] CTR_RESET = 3'd3;
    localparam logic [CTR_W-1:0] CTR_MAX   = 3'd7;
    localparam logic [CTR_W-1:0] CTR_TAKEN = 3'd4;
    localparam logic [CTR_W-1:0] CTR_MIN   = 3'd0;
    localparam logic [CTR_W-1:0] CTR_STEP  = 3'd1;

    // Target store reset value and sequential fetch step
    localparam logic [PC_W-1:0] TGT_RESET = '1;
    localparam logic [PC_W-1:0] PC_STEP   = 32'd4;

    typedef enum logic {
        CMD_PREDICT = 1'b0,
        CMD_RESOLVE = 1'b1
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_EQZ = 3'd0,
        KIND_GEZ = 3'd1,
        KIND_LEZ = 3'd2,
        KIND_GTZ = 3'd3,
        KIND_LTZ = 3'd4
    } t_kind;

    // Condition outcome: known kind, and whether the condition held
    typedef struct packed {
        logic known;
        logic holds;
    } t_cond;

    // Evaluate a zero-compare branch condition on a signed value
    function automatic t_cond cond_eval(logic [KIND_W-1:0] kind,
                                        logic signed [PC_W-1:0] value);
        t_cond res;
        logic  neg;
        logic  zero;
        neg  = value[PC_W-1];
        zero = (value == '0);
        res  = '{known: 1'b1, holds: 1'b0};
        case (kind)
            KIND_EQZ: res.holds = zero;
            KIND_GEZ: res.holds = !neg;
            KIND_LEZ: res.holds = neg || zero;
            KIND_GTZ: res.holds = !neg && !zero;
            KIND_LTZ: res.holds = neg;
            default:  res       = '{known: 1'b0, holds: 1'b0};
        endcase
        return res;
    endfunction

endpackage

@@ rtl/branch_target_predictor.sv @@
// Branch target predictor top level: slot pipeline, counter and target memories,
// training logic and result register.
// Depends on btp_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction per item: a
//   predict at fetch (i_cmd = 0) or a resolve of a branch outcome (i_cmd = 1).
//   Output channel (o_out_valid / i_out_ready) returns exactly one result
//   transaction per item, in order.
//   One item is accepted every cycle while o_in_ready is high. The slot is
//   (pc >> 2) mod ENTRIES, taken by a constant reciprocal multiply in stage
//   2; the counter and target memories are read with a registered port in
//   stage 3 and written as the item leaves it.
//   A write to the slot being read in the same cycle is forwarded.
//   After reset a clearing pass sets every counter to 3 and every target to
//   all ones; o_in_ready stays low until it completes.
//   When the receiver stalls, the whole pipeline holds; after the clearing
//   pass, o_in_ready drops only while a result waits and i_out_ready is low.
module branch_target_predictor
    import btp_pkg::*;
#(
    parameter int unsigned ENTRIES = BTP_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_cmd,
    input  logic [PC_W-1:0]        i_pc,
    input  logic                   i_is_branch,
    input  logic [KIND_W-1:0]      i_branch_kind,
    input  logic signed [PC_W-1:0] i_test_value,
    input  logic [PC_W-1:0]        i_branch_target,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [PC_W-1:0]        o_next_fetch_pc,
    output logic                   o_predicted_taken,
    output logic                   o_actual_taken,
    output logic                   o_mispredict,
    output logic [PC_W-1:0]        o_redirect_pc
);

    // Slot arithmetic: exact floor division of the word address by ENTRIES
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned WORD_W  = PC_W - 2;
    localparam int unsigned RCP_W   = WORD_W + 1;
    localparam int unsigned PROD_W  = WORD_W + RCP_W;
    localparam int unsigned SHIFT   = WORD_W + IDX_W;
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SHIFT) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
    localparam logic [RCP_W-1:0] RECIP     = RCP_FULL[RCP_W-1:0];
    localparam logic [IDX_W-1:0] ENT_LOW   = IDX_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

    // Pipeline advance and clearing state
    logic             w_adv;
    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_idx;

    // Stage 1: captured transaction
    logic                   r_v1;
    logic                   r_s1_cmd;
    logic [PC_W-1:0]        r_s1_pc;
    logic                   r_s1_isb;
    logic [KIND_W-1:0]      r_s1_kind;
    logic signed [PC_W-1:0] r_s1_tval;
    logic [PC_W-1:0]        r_s1_tgt;

    // Stage 2: reciprocal product
    logic                   r_v2;
    logic                   r_s2_cmd;
    logic [PC_W-1:0]        r_s2_pc;
    logic                   r_s2_isb;
    logic [KIND_W-1:0]      r_s2_kind;
    logic signed [PC_W-1:0] r_s2_tval;
    logic [PC_W-1:0]        r_s2_tgt;
    logic [PROD_W-1:0]      r_s2_prod;
    logic [IDX_W-1:0]       w_q_low;
    logic [IDX_W-1:0]       w_s2_slot;

    // Stage 3: slot and memory read data
    logic                   r_v3;
    logic                   r_s3_cmd;
    logic [PC_W-1:0]        r_s3_pc;
    logic                   r_s3_isb;
    logic [KIND_W-1:0]      r_s3_kind;
    logic signed [PC_W-1:0] r_s3_tval;
    logic [PC_W-1:0]        r_s3_tgt;
    logic [IDX_W-1:0]       r_s3_slot;
    logic [CTR_W-1:0]       r_s3_ctr;
    logic [PC_W-1:0]        r_s3_stored;

    // Memories
    logic [CTR_W-1:0] mem_ctr [ENTRIES];
    logic [PC_W-1:0]  mem_tgt [ENTRIES];

    // Training and write port
    logic             w_strong;
    t_cond            w_cond;
    logic [PC_W-1:0]  w_seq;
    logic [CTR_W-1:0] w_ctr_new;
    logic             w_train;
    logic             w_ctr_we;
    logic             w_tgt_we;
    logic [IDX_W-1:0] w_waddr;
    logic [CTR_W-1:0] w_ctr_wdata;
    logic [PC_W-1:0]  w_tgt_wdata;

    // Output register
    logic             r_out_valid;
    logic [PC_W-1:0]  r_next_fetch_pc;
    logic             r_predicted_taken;
    logic             r_actual_taken;
    logic             r_mispredict;
    logic [PC_W-1:0]  r_redirect_pc;
    logic [PC_W-1:0]  n_next_fetch_pc;
    logic             n_predicted_taken;
    logic             n_actual_taken;
    logic             n_mispredict;
    logic [PC_W-1:0]  n_redirect_pc;

    // Advance the whole pipeline unless a result waits on a stalled receiver
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv && !r_clr_active;

    // Hold valid flags and sweep the memories after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_clr_active <= 1'b1;
            r_clr_idx    <= '0;
        end else begin
            if (w_adv) begin
                r_v1        <= i_in_valid && !r_clr_active;
                r_v2        <= r_v1;
                r_v3        <= r_v2;
                r_out_valid <= r_v3;
            end
            if (r_clr_active) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
                if (r_clr_idx == LAST_SLOT) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    // Advance payload through stages 1, 2 and 3
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_cmd  <= i_cmd;
            r_s1_pc   <= i_pc;
            r_s1_isb  <= i_is_branch;
            r_s1_kind <= i_branch_kind;
            r_s1_tval <= i_test_value;
            r_s1_tgt  <= i_branch_target;

            r_s2_cmd  <= r_s1_cmd;
            r_s2_pc   <= r_s1_pc;
            r_s2_isb  <= r_s1_isb;
            r_s2_kind <= r_s1_kind;
            r_s2_tval <= r_s1_tval;
            r_s2_tgt  <= r_s1_tgt;
            r_s2_prod <= {{(PROD_W-WORD_W){1'b0}}, r_s1_pc[PC_W-1:2]}
                       * {{(PROD_W-RCP_W){1'b0}}, RECIP};

            r_s3_cmd  <= r_s2_cmd;
            r_s3_pc   <= r_s2_pc;
            r_s3_isb  <= r_s2_isb;
            r_s3_kind <= r_s2_kind;
            r_s3_tval <= r_s2_tval;
            r_s3_tgt  <= r_s2_tgt;
            r_s3_slot <= w_s2_slot;
        end
    end

    // Remainder from the low quotient bits: it is below 2^IDX_W, so low bits suffice
    assign w_q_low   = r_s2_prod[SHIFT +: IDX_W];
    assign w_s2_slot = r_s2_pc[IDX_W+1:2] - IDX_W'(w_q_low * ENT_LOW);

    // Train the entry of a resolved branch with a known condition
    always_comb begin
        w_seq    = r_s3_pc + PC_STEP;
        w_strong = (r_s3_ctr >= CTR_TAKEN);
        w_cond   = cond_eval(r_s3_kind, r_s3_tval);
        if (w_cond.holds) begin
            w_ctr_new = (r_s3_ctr < CTR_MAX) ? r_s3_ctr + CTR_STEP : r_s3_ctr;
        end else begin
            w_ctr_new = (r_s3_ctr != CTR_MIN) ? r_s3_ctr - CTR_STEP : r_s3_ctr;
        end
        w_train = w_adv && r_v3 && (r_s3_cmd == CMD_RESOLVE) && w_cond.known;
    end

    // Select the write port source: clearing pass or training
    always_comb begin
        if (r_clr_active) begin
            w_waddr     = r_clr_idx;
            w_ctr_we    = 1'b1;
            w_tgt_we    = 1'b1;
            w_ctr_wdata = CTR_RESET;
            w_tgt_wdata = TGT_RESET;
        end else begin
            w_waddr     = r_s3_slot;
            w_ctr_we    = w_train;
            w_tgt_we    = w_train && !w_strong;
            w_ctr_wdata = w_ctr_new;
            w_tgt_wdata = r_s3_tgt;
        end
    end

    // Write the memories and capture read data, forwarding a same-slot write
    always_ff @(posedge i_clk) begin
        if (w_ctr_we) begin
            mem_ctr[w_waddr] <= w_ctr_wdata;
        end
        if (w_tgt_we) begin
            mem_tgt[w_waddr] <= w_tgt_wdata;
        end
        if (w_adv) begin
            r_s3_ctr    <= (w_ctr_we && (w_waddr == w_s2_slot)) ? w_ctr_wdata
                                                                : mem_ctr[w_s2_slot];
            r_s3_stored <= (w_tgt_we && (w_waddr == w_s2_slot)) ? w_tgt_wdata
                                                                : mem_tgt[w_s2_slot];
        end
    end

    // Form the result of the item in stage 3
    always_comb begin
        n_next_fetch_pc   = '0;
        n_predicted_taken = 1'b0;
        n_actual_taken    = 1'b0;
        n_mispredict      = 1'b0;
        n_redirect_pc     = '0;
        unique case (r_s3_cmd)
            CMD_PREDICT: begin
                n_predicted_taken = r_s3_isb && w_strong;
                n_next_fetch_pc   = (r_s3_isb && w_strong) ? r_s3_stored : w_seq;
            end
            CMD_RESOLVE: begin
                n_predicted_taken = w_strong;
                n_actual_taken    = w_cond.holds;
                n_mispredict      = w_cond.known && (w_cond.holds != w_strong);
                n_redirect_pc     = w_cond.holds ? r_s3_tgt : w_seq;
            end
        endcase
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_next_fetch_pc   <= n_next_fetch_pc;
            r_predicted_taken <= n_predicted_taken;
            r_actual_taken    <= n_actual_taken;
            r_mispredict      <= n_mispredict;
            r_redirect_pc     <= n_redirect_pc;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_next_fetch_pc   = r_next_fetch_pc;
    assign o_predicted_taken = r_predicted_taken;
    assign o_actual_taken    = r_actual_taken;
    assign o_mispredict      = r_mispredict;
    assign o_redirect_pc     = r_redirect_pc;

    // A mispredict always means the outcome disagreed with the counter
    a_miss_disagrees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mispredict |-> o_actual_taken != o_predicted_taken)
        else $error("mispredict flagged while outcome matched prediction");

    // A taken resolve carries no fetch pc
    a_resolve_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_actual_taken |-> o_next_fetch_pc == '0)
        else $error("resolve result carries a fetch pc");

    // The computed slot stays inside the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> 32'(w_s2_slot) < ENTRIES)
        else $error("slot index beyond table size");

    // No item reaches the memory stage while the clearing pass runs
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |=> !r_v3)
        else $error("item in flight during clearing pass");

endmodule

@@ tb/sv/branch_target_predictor_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for branch_target_predictor: drives predict and resolve
// transactions, mirrors the counter and target tables, and checks every result.
// Depends on btp_pkg and the branch_target_predictor RTL.
module branch_target_predictor_test;
    import btp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned MAX_PRINTS  = 50;

    typedef struct packed {
        logic [PC_W-1:0] next_fetch_pc;
        logic            predicted_taken;
        logic            actual_taken;
        logic            mispredict;
        logic [PC_W-1:0] redirect_pc;
    } t_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_cmd = 1'b0;
    logic [PC_W-1:0]        i_pc = '0;
    logic                   i_is_branch = 1'b0;
    logic [KIND_W-1:0]      i_branch_kind = '0;
    logic signed [PC_W-1:0] i_test_value = '0;
    logic [PC_W-1:0]        i_branch_target = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [PC_W-1:0]        o_next_fetch_pc;
    logic                   o_predicted_taken;
    logic                   o_actual_taken;
    logic                   o_mispredict;
    logic [PC_W-1:0]        o_redirect_pc;

    // Mirror of the branch target buffer
    logic [CTR_W-1:0] btb_counter [BTP_ENTRIES_DEF];
    logic [PC_W-1:0]  btb_target  [BTP_ENTRIES_DEF];

    t_result     pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          idle_on = 1'b0;
    logic [PC_W-1:0] hot_pcs [8];

    branch_target_predictor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_pc              (i_pc),
        .i_is_branch       (i_is_branch),
        .i_branch_kind     (i_branch_kind),
        .i_test_value      (i_test_value),
        .i_branch_target   (i_branch_target),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_next_fetch_pc   (o_next_fetch_pc),
        .o_predicted_taken (o_predicted_taken),
        .o_actual_taken    (o_actual_taken),
        .o_mispredict      (o_mispredict),
        .o_redirect_pc     (o_redirect_pc)
    );

    // Toggle the clock every half period
    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("branch_target_predictor_test failed");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 0;
        else if (r < 96)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Work out the result of one transaction and train the mirrored entry
    function automatic t_result predict_outcome(t_cmd cmd, logic [PC_W-1:0] pc,
                                                logic is_branch, logic [KIND_W-1:0] kind,
                                                logic [PC_W-1:0] value,
                                                logic [PC_W-1:0] target);
        t_result          res;
        int unsigned      slot;
        logic [CTR_W-1:0] ctr;
        logic [PC_W-1:0]  seq_pc;
        logic             ctr_high;
        logic             known;
        logic             taken;
        logic             neg;
        logic             zero;
        slot     = (pc >> 2) % BTP_ENTRIES_DEF;
        ctr      = btb_counter[slot];
        seq_pc   = pc + PC_STEP;
        ctr_high = (ctr >= CTR_TAKEN);
        res      = '0;
        if (cmd == CMD_PREDICT) begin
            res.predicted_taken = is_branch && ctr_high;
            res.next_fetch_pc   = res.predicted_taken ? btb_target[slot] : seq_pc;
            return res;
        end
        neg   = value[PC_W-1];
        zero  = (value == '0);
        known = 1'b1;
        taken = 1'b0;
        case (kind)
            KIND_EQZ: taken = zero;
            KIND_GEZ: taken = !neg;
            KIND_LEZ: taken = neg || zero;
            KIND_GTZ: taken = !neg && !zero;
            KIND_LTZ: taken = neg;
            default:  known = 1'b0;
        endcase
        // Train the entry only for a known condition
        if (known) begin
            if (taken) begin
                if (!ctr_high) begin
                    btb_target[slot] = target;
                    res.mispredict   = 1'b1;
                end
                if (ctr != CTR_MAX)
                    ctr = ctr + CTR_STEP;
            end else begin
                if (ctr_high)
                    res.mispredict = 1'b1;
                else
                    btb_target[slot] = target;
                if (ctr != CTR_MIN)
                    ctr = ctr - CTR_STEP;
            end
            btb_counter[slot] = ctr;
        end
        res.predicted_taken = ctr_high;
        res.actual_taken    = taken;
        res.redirect_pc     = taken ? target : seq_pc;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [PC_W-1:0] got,
                                   logic [PC_W-1:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("mismatch %s: got %h expected %h (cycle %0d)",
                     what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Send one transaction; called and returns at a falling edge
    task automatic send_item(t_cmd cmd, logic [PC_W-1:0] pc, logic is_branch,
                             logic [KIND_W-1:0] kind, logic [PC_W-1:0] value,
                             logic [PC_W-1:0] target);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_pc            <= pc;
        i_is_branch     <= is_branch;
        i_branch_kind   <= kind;
        i_test_value    <= value;
        i_branch_target <= target;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_results.push_back(predict_outcome(cmd, pc, is_branch, kind, value, target));
        @(negedge i_clk);
    endtask

    // Predict with the resolve-only fields filled with noise
    task automatic send_predict(logic [PC_W-1:0] pc, logic is_branch);
        send_item(CMD_PREDICT, pc, is_branch, KIND_W'($urandom_range(0, 7)),
                  $urandom, $urandom);
    endtask

    // Resolve with is_branch filled with noise
    task automatic send_resolve(logic [PC_W-1:0] pc, logic [KIND_W-1:0] kind,
                                logic [PC_W-1:0] value, logic [PC_W-1:0] target);
        send_item(CMD_RESOLVE, pc, 1'($urandom_range(0, 1)), kind, value, target);
    endtask

    // Drive the result ready with random stalls
    always @(negedge i_clk) begin
        if (stall_left == 0)
            stall_left = idle_cycles();
        if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, next_fetch_pc", o_next_fetch_pc, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_next_fetch_pc !== want.next_fetch_pc)
                    report_mismatch("next_fetch_pc", o_next_fetch_pc, want.next_fetch_pc);
                if (o_predicted_taken !== want.predicted_taken)
                    report_mismatch("predicted_taken", PC_W'(o_predicted_taken),
                                    PC_W'(want.predicted_taken));
                if (o_actual_taken !== want.actual_taken)
                    report_mismatch("actual_taken", PC_W'(o_actual_taken),
                                    PC_W'(want.actual_taken));
                if (o_mispredict !== want.mispredict)
                    report_mismatch("mispredict", PC_W'(o_mispredict),
                                    PC_W'(want.mispredict));
                if (o_redirect_pc !== want.redirect_pc)
                    report_mismatch("redirect_pc", o_redirect_pc, want.redirect_pc);
            end
        end
    end

    // Fresh table: nothing is predicted taken, pc + 4 wraps at the top
    task automatic test_reset_state();
        send_predict(32'h0000_0000, 1'b1);
        send_predict(32'hFFFF_FFFC, 1'b1);
        send_predict(32'hFFFF_FFFF, 1'b0);
    endtask

    // Walk one entry up to saturation and back down through every condition
    task automatic test_counter_training();
        send_resolve(32'h0000_0040, KIND_EQZ, 32'h0000_0000, 32'h1234_5678);
        send_predict(32'h0000_0040, 1'b1);
        send_predict(32'h0000_0041, 1'b0);
        send_resolve(32'h0000_0040, KIND_GEZ, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        send_resolve(32'h0000_0040, KIND_GTZ, 32'h0000_0001, 32'h5555_5555);
        send_resolve(32'h0000_0040, KIND_LEZ, 32'h8000_0000, 32'h0000_0000);
        send_resolve(32'h0000_0040, KIND_LTZ, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_predict(32'hFFFF_FF80, 1'b1);
        send_resolve(32'h0000_0040, KIND_EQZ, 32'h0000_0001, 32'h0F0F_0F0F);
        send_resolve(32'h0000_0040, KIND_GEZ, 32'h8000_0000, 32'hF0F0_F0F0);
        send_resolve(32'h0000_0040, KIND_LEZ, 32'h0000_0001, 32'h1111_1111);
        send_resolve(32'h0000_0040, KIND_GTZ, 32'h0000_0000, 32'h2222_2222);
        send_resolve(32'h0000_0040, KIND_LTZ, 32'h0000_0000, 32'h3333_3333);
        send_resolve(32'h0000_0040, KIND_EQZ, 32'h0000_0005, 32'h4444_4444);
        send_resolve(32'h0000_0040, KIND_EQZ, 32'hFFFF_FFFB, 32'h6666_6666);
        send_resolve(32'h0000_0040, KIND_EQZ, 32'h7FFF_FFFF, 32'h7777_7777);
        send_predict(32'h0000_0040, 1'b1);
    endtask

    // Unknown kinds leave the entry alone; redirect wraps at the top
    task automatic test_unknown_kinds();
        send_resolve(32'hFFFF_FFFC, KIND_W'(5), 32'h0000_0000, 32'h8888_8888);
        send_resolve(32'hFFFF_FFFC, KIND_W'(6), 32'h8000_0000, 32'h9999_9999);
        send_resolve(32'hFFFF_FFFC, KIND_W'(7), 32'h0000_0001, 32'hBBBB_BBBB);
        send_resolve(32'hFFFF_FFFC, KIND_EQZ, 32'h0000_0001, 32'hCCCC_CCCC);
        send_predict(32'hFFFF_FFFC, 1'b1);
    endtask

    // Mixed traffic, mostly on a few aliasing addresses so entries get trained
    task automatic test_random_traffic(int unsigned count);
        logic [PC_W-1:0]   pc;
        logic [KIND_W-1:0] kind;
        logic [PC_W-1:0]   value;
        foreach (hot_pcs[i])
            hot_pcs[i] = ($urandom & ~32'h0000_003C) | (PC_W'($urandom_range(0, 3)) << 2);
        repeat (count) begin
            pc = ($urandom_range(0, 99) < 80) ? hot_pcs[$urandom_range(0, 7)] : $urandom;
            if ($urandom_range(0, 1) == 0) begin
                send_predict(pc, $urandom_range(0, 99) < 75);
            end else begin
                kind = ($urandom_range(0, 99) < 90) ? KIND_W'($urandom_range(0, 4))
                                                    : KIND_W'($urandom_range(5, 7));
                case ($urandom_range(0, 3))
                    0:       value = '0;
                    1:       value = PC_W'(int'($urandom_range(0, 6)) - 3);
                    default: value = $urandom;
                endcase
                send_resolve(pc, kind, value, $urandom);
            end
        end
    endtask

    initial begin
        foreach (btb_counter[i]) begin
            btb_counter[i] = CTR_RESET;
            btb_target[i]  = TGT_RESET;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_counter_training();
        test_unknown_kinds();
        idle_on = 1'b1;
        test_random_traffic(900);
        idle_on = 1'b0;
        test_random_traffic(150);
        idle_on = 1'b1;
        test_random_traffic(900);

        // Drain the outstanding results, then allow for stray ones
        i_in_valid <= 1'b0;
        idle_on = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("branch_target_predictor_test passed");
        else
            $display("branch_target_predictor_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/btp_pkg.sv
rtl/branch_target_predictor.sv
tb/sv/branch_target_predictor_test.sv
